@@ rtl/assert_macros.svh @@
// Assertion macros used by the port-level checker of this project.
// Include guard only; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ rtl/vc2d_pkg.sv @@
// Shared types and constants for the streaming 2-D cross-correlation block.
// No dependencies; the block's modules and interfaces refer to it by scoped names.
`timescale 1ns / 1ps

package vc2d_pkg;

    localparam int KERNEL_MAX_DEF = 5;
    localparam int WIDTH_MAX_DEF  = 1024;
    localparam int HEIGHT_MAX     = 1024;

    localparam int SAMPLE_W    = 16;
    localparam int PROD_W      = 32;
    localparam int SUM_W       = 36;
    localparam int COEFF_IDX_W = 5;
    localparam int POS_W       = 10;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;
    localparam int KCFG_W      = 3;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH   = 2'd0,
        CFG_IMAGE_HEIGHT  = 2'd1,
        CFG_KERNEL_HEIGHT = 2'd2,
        CFG_KERNEL_WIDTH  = 2'd3
    } cfg_reg_e;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [SUM_W-1:0]    sum_t;

    // Per-cycle strobes that move the window cells forward.
    typedef struct packed {
        logic shift;
        logic mult;
        logic add;
    } cell_ctrl_t;

endpackage

@@ rtl/vc2d_req_if.sv @@
// Input channel: kernel coefficient loads and image samples.
// Depends on vc2d_pkg for field widths.
`timescale 1ns / 1ps

interface vc2d_req_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 req_type;
    logic [vc2d_pkg::COEFF_IDX_W-1:0]     coeff_index;
    logic signed [vc2d_pkg::SAMPLE_W-1:0] value;

    modport source (output valid, req_type, coeff_index, value, input ready);
    modport sink   (input valid, req_type, coeff_index, value, output ready);
endinterface

@@ rtl/vc2d_rsp_if.sv @@
// Output channel: window sums with their output position.
// Depends on vc2d_pkg for field widths.
`timescale 1ns / 1ps

interface vc2d_rsp_if;
    logic                              valid;
    logic                              ready;
    logic signed [vc2d_pkg::SUM_W-1:0] sum;
    logic [vc2d_pkg::POS_W-1:0]        out_row;
    logic [vc2d_pkg::POS_W-1:0]        out_col;
    logic                              last_of_image;

    modport source (output valid, sum, out_row, out_col, last_of_image, input ready);
    modport sink   (input valid, sum, out_row, out_col, last_of_image, output ready);
endinterface

@@ rtl/vc2d_ram.sv @@
// Generic single-write, single-read RAM with registered read data (read-first).
// Depends on vc2d_pkg only for default parameter values.
`timescale 1ns / 1ps

module vc2d_ram #(
    parameter int WIDTH = vc2d_pkg::SAMPLE_W,
    parameter int DEPTH = vc2d_pkg::WIDTH_MAX_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/vc2d_cell.sv @@
// One window column cell: holds a column of samples, passes it on when the
// window slides, and forms the column's registered products and sum.
// Depends on vc2d_pkg.
`timescale 1ns / 1ps

module vc2d_cell #(
    parameter int KERNEL_MAX = vc2d_pkg::KERNEL_MAX_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  vc2d_pkg::cell_ctrl_t ctrl,
    input  vc2d_pkg::sample_t    col_in  [KERNEL_MAX],
    input  vc2d_pkg::sample_t    coef_in [KERNEL_MAX],
    output vc2d_pkg::sample_t    col_out [KERNEL_MAX],
    output vc2d_pkg::sum_t       csum
);

    vc2d_pkg::sample_t col_reg  [KERNEL_MAX];
    vc2d_pkg::sample_t coef_reg [KERNEL_MAX];
    vc2d_pkg::prod_t   prod_reg [KERNEL_MAX];
    vc2d_pkg::sum_t    csum_reg;
    vc2d_pkg::sum_t    csum_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < KERNEL_MAX; b++)
            begin
                col_reg[b] <= '0;
            end
        end
        else if (ctrl.shift)
        begin
            col_reg <= col_in;
        end
    end

    always_ff @(posedge clk)
    begin
        coef_reg <= coef_in;
        if (ctrl.mult)
        begin
            for (int b = 0; b < KERNEL_MAX; b++)
            begin
                prod_reg[b] <= vc2d_pkg::prod_t'(col_reg[b]) * vc2d_pkg::prod_t'(coef_reg[b]);
            end
        end
        if (ctrl.add)
        begin
            csum_reg <= csum_next;
        end
    end

    always_comb
    begin
        csum_next = '0;
        for (int b = 0; b < KERNEL_MAX; b++)
        begin
            csum_next = csum_next + vc2d_pkg::sum_t'(prod_reg[b]);
        end
    end

    assign col_out = col_reg;
    assign csum    = csum_reg;

endmodule

@@ rtl/valid_2d_convolution.sv @@
// Streaming valid 2-D cross-correlation. Load transactions write Q2.14 kernel
// coefficients; sample transactions carry Q8.8 pixels in raster order, one per
// cycle. Each sample produces at most one Q14.22 sum, delivered through a
// registered output; the pipeline (line RAM read, window slide, products,
// column sums, final sum) takes a new sample every cycle and stalls only when
// the output register is full and not taken. A load waits until the two front
// stages hold no sample. The line buffers need no clearing pass after reset.
// Configuration writes restart the image.
// Depends on vc2d_pkg, vc2d_req_if, vc2d_rsp_if, vc2d_ram and vc2d_cell.
`timescale 1ns / 1ps

module valid_2d_convolution #(
    parameter int KERNEL_MAX = vc2d_pkg::KERNEL_MAX_DEF,
    parameter int WIDTH_MAX  = vc2d_pkg::WIDTH_MAX_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [vc2d_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [vc2d_pkg::CFG_DATA_W-1:0]  cfg_data,
    vc2d_req_if.sink                         req,
    vc2d_rsp_if.source                       rsp
);

    localparam int KSLOTS = KERNEL_MAX * KERNEL_MAX;
    localparam int LINES  = (KERNEL_MAX > 1) ? KERNEL_MAX - 1 : 1;
    localparam int LB     = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int KIB    = (KSLOTS > 1) ? $clog2(KSLOTS) : 1;
    localparam int CB     = $clog2(WIDTH_MAX);
    localparam int WB     = $clog2(WIDTH_MAX + 1);
    localparam int KB     = $clog2(KERNEL_MAX + 1);
    localparam int HW     = vc2d_pkg::CFG_DATA_W;
    localparam int W_RST  = (WIDTH_MAX < 1024) ? WIDTH_MAX : 1024;
    localparam int K_RST  = (KERNEL_MAX < 3) ? KERNEL_MAX : 3;

    typedef struct packed {
        logic                       last;
        logic [vc2d_pkg::POS_W-1:0] row;
        logic [vc2d_pkg::POS_W-1:0] col;
    } meta_t;

    // Configuration, stored already clamped.
    logic [WB-1:0] w_reg;
    logic [HW-1:0] h_reg;
    logic [KB-1:0] kh_reg;
    logic [KB-1:0] kw_reg;
    logic [WB-1:0] w_next;
    logic [HW-1:0] h_next;
    logic [KB-1:0] k_next;
    logic [vc2d_pkg::KCFG_W-1:0] kfield;

    // Raster position and the line bank that the current row writes.
    logic [CB-1:0]                c_reg;
    logic [vc2d_pkg::POS_W-1:0]   r_reg;
    logic [LB-1:0]                rb_reg;
    logic                         row_end;
    logic                         img_end;

    vc2d_pkg::sample_t kern_reg [KSLOTS];

    logic acc_sample;
    logic acc_load;
    logic emit;
    meta_t meta_now;

    logic rdy_out, rdy1, rdy2, rdy3, rdy4;
    logic mv1, mv2, mv3, mv4;

    logic              s1_valid, s2_valid, s3_valid, s4_valid, o_valid;
    logic              s1_emit, s2_emit;
    meta_t             s1_meta, s2_meta, s3_meta, s4_meta, o_meta;
    vc2d_pkg::sample_t s1_v;
    logic [LB-1:0]     s1_rb;
    vc2d_pkg::sum_t    o_sum;
    vc2d_pkg::sum_t    tot;

    vc2d_pkg::sample_t    ram_rd   [LINES];
    vc2d_pkg::sample_t    tap      [KERNEL_MAX+1][KERNEL_MAX];
    vc2d_pkg::sample_t    coef_map [KERNEL_MAX][KERNEL_MAX];
    vc2d_pkg::sum_t       csum     [KERNEL_MAX];
    vc2d_pkg::cell_ctrl_t cell_ctrl;

    // ---------------- configuration ----------------
    always_comb
    begin
        kfield = cfg_data[vc2d_pkg::KCFG_W-1:0];
        if (cfg_data == '0)
            w_next = WB'(1);
        else if (32'(cfg_data) > WIDTH_MAX)
            w_next = WB'(WIDTH_MAX);
        else
            w_next = WB'(cfg_data);
        if (cfg_data == '0)
            h_next = HW'(1);
        else if (32'(cfg_data) > vc2d_pkg::HEIGHT_MAX)
            h_next = HW'(vc2d_pkg::HEIGHT_MAX);
        else
            h_next = cfg_data;
        if (kfield == '0)
            k_next = KB'(1);
        else if (32'(kfield) > KERNEL_MAX)
            k_next = KB'(KERNEL_MAX);
        else
            k_next = KB'(kfield);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg  <= WB'(W_RST);
            h_reg  <= HW'(vc2d_pkg::HEIGHT_MAX);
            kh_reg <= KB'(K_RST);
            kw_reg <= KB'(K_RST);
        end
        else if (cfg_we)
        begin
            unique case (vc2d_pkg::cfg_reg_e'(cfg_index))
                vc2d_pkg::CFG_IMAGE_WIDTH:   w_reg  <= w_next;
                vc2d_pkg::CFG_IMAGE_HEIGHT:  h_reg  <= h_next;
                vc2d_pkg::CFG_KERNEL_HEIGHT: kh_reg <= k_next;
                vc2d_pkg::CFG_KERNEL_WIDTH:  kw_reg <= k_next;
                default: ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    assign rdy_out = !o_valid || rsp.ready;
    assign rdy4    = !s4_valid || rdy_out;
    assign rdy3    = !s3_valid || rdy4;
    assign rdy2    = !s2_valid || rdy3;
    assign rdy1    = !s1_valid || rdy2;
    assign mv1     = s1_valid && rdy2;
    assign mv2     = s2_valid && rdy3;
    assign mv3     = s3_valid && rdy4;
    assign mv4     = s4_valid && rdy_out;

    // A load must not change the kernel under a sample that has not yet
    // reached the multipliers.
    assign req.ready  = (req.req_type == vc2d_pkg::REQ_SAMPLE) ? rdy1
                                                               : !(s1_valid || s2_valid);
    assign acc_sample = req.valid && req.ready && (req.req_type == vc2d_pkg::REQ_SAMPLE);
    assign acc_load   = req.valid && req.ready && (req.req_type == vc2d_pkg::REQ_LOAD);

    // ---------------- kernel store ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KSLOTS; i++)
            begin
                kern_reg[i] <= '0;
            end
        end
        else if (acc_load && (32'(req.coeff_index) < KSLOTS))
        begin
            kern_reg[KIB'(req.coeff_index)] <= req.value;
        end
    end

    // Cell j holds the column taken j samples ago; element b is the row b above
    // the current one. The matching coefficient is kernel[(kh-1-b)*kw + kw-1-j].
    always_comb
    begin
        int kidx;
        kidx = 0;
        for (int j = 0; j < KERNEL_MAX; j++)
        begin
            for (int b = 0; b < KERNEL_MAX; b++)
            begin
                if ((b < 32'(kh_reg)) && (j < 32'(kw_reg)))
                begin
                    kidx = (32'(kh_reg) - 1 - b) * 32'(kw_reg) + (32'(kw_reg) - 1 - j);
                    coef_map[j][b] = kern_reg[KIB'(kidx)];
                end
                else
                begin
                    coef_map[j][b] = '0;
                end
            end
        end
    end

    // ---------------- raster position ----------------
    always_comb
    begin
        row_end      = (32'(c_reg) + 1) >= 32'(w_reg);
        img_end      = (32'(r_reg) + 1) >= 32'(h_reg);
        emit         = ((32'(r_reg) + 1) >= 32'(kh_reg)) && ((32'(c_reg) + 1) >= 32'(kw_reg));
        meta_now.last = ((32'(r_reg) + 1) == 32'(h_reg)) && ((32'(c_reg) + 1) == 32'(w_reg));
        meta_now.row  = vc2d_pkg::POS_W'(32'(r_reg) + 1 - 32'(kh_reg));
        meta_now.col  = vc2d_pkg::POS_W'(32'(c_reg) + 1 - 32'(kw_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_reg  <= '0;
            r_reg  <= '0;
            rb_reg <= '0;
        end
        else if (cfg_we)
        begin
            c_reg  <= '0;
            r_reg  <= '0;
            rb_reg <= '0;
        end
        else if (acc_sample)
        begin
            if (row_end)
            begin
                c_reg <= '0;
                if (img_end)
                begin
                    r_reg  <= '0;
                    rb_reg <= '0;
                end
                else
                begin
                    r_reg  <= r_reg + 1'b1;
                    rb_reg <= (32'(rb_reg) == LINES - 1) ? '0 : rb_reg + 1'b1;
                end
            end
            else
            begin
                c_reg <= c_reg + 1'b1;
            end
        end
    end

    // ---------------- line buffers ----------------
    for (genvar i = 0; i < LINES; i++)
    begin : g_line
        vc2d_ram #(
            .WIDTH (vc2d_pkg::SAMPLE_W),
            .DEPTH (WIDTH_MAX)
        ) u_ram (
            .clk   (clk),
            .we    (acc_sample && (rb_reg == LB'(i))),
            .waddr (c_reg),
            .wdata (req.value),
            .re    (acc_sample),
            .raddr (c_reg),
            .rdata (ram_rd[i])
        );
    end

    // ---------------- pipeline valids ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid <= 1'b0;
            s2_valid <= 1'b0;
            s3_valid <= 1'b0;
            s4_valid <= 1'b0;
            o_valid  <= 1'b0;
        end
        else
        begin
            if (acc_sample)
                s1_valid <= 1'b1;
            else if (mv1)
                s1_valid <= 1'b0;
            if (mv1)
                s2_valid <= 1'b1;
            else if (mv2)
                s2_valid <= 1'b0;
            // Samples that complete no window leave after the slide.
            if (mv2)
                s3_valid <= s2_emit;
            else if (mv3)
                s3_valid <= 1'b0;
            if (mv3)
                s4_valid <= 1'b1;
            else if (mv4)
                s4_valid <= 1'b0;
            if (mv4)
                o_valid <= 1'b1;
            else if (rsp.ready)
                o_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_sample)
        begin
            s1_v    <= req.value;
            s1_rb   <= rb_reg;
            s1_emit <= emit;
            s1_meta <= meta_now;
        end
        if (mv1)
        begin
            s2_emit <= s1_emit;
            s2_meta <= s1_meta;
        end
        if (mv2)
        begin
            s3_meta <= s2_meta;
        end
        if (mv3)
        begin
            s4_meta <= s3_meta;
        end
        if (mv4)
        begin
            o_meta <= s4_meta;
            o_sum  <= tot;
        end
    end

    // ---------------- window cells ----------------
    // New column: the sample itself, then the rows above from their line banks.
    // Rows outside the kernel are forced to zero.
    always_comb
    begin
        int bidx;
        bidx = 0;
        for (int b = 0; b < KERNEL_MAX; b++)
        begin
            bidx = 32'(s1_rb) + LINES - b;
            if (bidx >= LINES)
                bidx = bidx - LINES;
            if (b >= 32'(kh_reg))
                tap[0][b] = '0;
            else if (b == 0)
                tap[0][b] = s1_v;
            else
                tap[0][b] = ram_rd[LB'(bidx)];
        end
    end

    assign cell_ctrl.shift = mv1;
    assign cell_ctrl.mult  = mv2;
    assign cell_ctrl.add   = mv3;

    for (genvar j = 0; j < KERNEL_MAX; j++)
    begin : g_cell
        vc2d_cell #(
            .KERNEL_MAX (KERNEL_MAX)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (cell_ctrl),
            .col_in  (tap[j]),
            .coef_in (coef_map[j]),
            .col_out (tap[j+1]),
            .csum    (csum[j])
        );
    end

    always_comb
    begin
        tot = '0;
        for (int j = 0; j < KERNEL_MAX; j++)
        begin
            tot = tot + csum[j];
        end
    end

    // ---------------- output ----------------
    assign rsp.valid         = o_valid;
    assign rsp.sum           = o_sum;
    assign rsp.out_row       = o_meta.row;
    assign rsp.out_col       = o_meta.col;
    assign rsp.last_of_image = o_meta.last;

endmodule

@@ rtl/vc2d_checker.sv @@
// Port-level checks for valid_2d_convolution, attached by the bind below.
// Depends on vc2d_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vc2d_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          req_type,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [vc2d_pkg::SUM_W-1:0]    rsp_sum
);

    // A held result stays offered with the same sum.
    `ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid)
    `ASSERT_NEXT(a_rsp_stable, clk, rst_n, rsp_valid && !rsp_ready, $stable(rsp_sum))
    // Samples are refused only when the whole pipe is backed up behind the output.
    `ASSERT_IMPLIES(a_sample_backpressure, clk, rst_n, req_type == vc2d_pkg::REQ_SAMPLE && !req_ready, rsp_valid && !rsp_ready)
    `ASSERT_IMPLIES(a_reset_quiet, clk, rst_n, $rose(rst_n), !rsp_valid)

endmodule

bind valid_2d_convolution vc2d_checker u_vc2d_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_type  (req.req_type),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_sum   (rsp.sum)
);

@@ tb/vc2d_window_sum_checker.sv @@
// Checker for the streaming 2-D cross-correlation block: predicts window sums.
// It watches the configuration port and both channels and compares every result.
// Depends on vc2d_pkg, vc2d_req_if and vc2d_rsp_if.
`timescale 1ns / 1ps

module vc2d_window_sum_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [vc2d_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vc2d_pkg::CFG_DATA_W-1:0] cfg_data,
    vc2d_req_if                             req,
    vc2d_rsp_if                             rsp,
    output int                              errors,
    output int                              pending
);
    import vc2d_pkg::*;

    localparam int KMAX   = 5;
    localparam int KSLOTS = KMAX * KMAX;
    localparam int WMAX   = 1024;
    localparam int NLINES = 4;

    typedef struct packed {
        sum_t             sum;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             last;
    } window_sum_t;

    window_sum_t         expected_sums[$];
    logic [10:0]         img_w;
    logic [10:0]         img_h;
    logic [2:0]          k_h;
    logic [2:0]          k_w;
    sample_t             coeffs[KSLOTS];
    sample_t             lines[NLINES][WMAX];
    sample_t             win[KMAX][KMAX];
    int unsigned         row_cnt;
    int unsigned         col_cnt;

    function automatic int unsigned clamp_to(int unsigned v, int unsigned lo,
                                             int unsigned hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic void apply_sample(input sample_t v);
        int unsigned        w, h, kh, kw, r, c, back;
        logic signed [63:0] acc;
        logic signed [63:0] a;
        logic signed [63:0] b;
        window_sum_t        res;
        w  = clamp_to(img_w, 1, WMAX);
        h  = clamp_to(img_h, 1, 1024);
        kh = clamp_to(k_h, 1, KMAX);
        kw = clamp_to(k_w, 1, KMAX);
        r  = row_cnt;
        c  = col_cnt;
        if (c >= w)
            c = w - 1;
        if (r >= h)
            r = h - 1;
        for (int kr = 0; kr < KMAX; kr++)
            for (int kc = 0; kc < KMAX - 1; kc++)
                win[kr][kc] = win[kr][kc+1];
        // The newest column enters at the right edge of the active kernel.
        for (int kr = 0; kr < kh; kr++)
        begin
            back = kh - 1 - kr;
            if (back == 0)
                win[kr][kw-1] = v;
            else
                win[kr][kw-1] = lines[(r + NLINES * 1024 - back) % NLINES][c];
        end
        lines[r % NLINES][c] = v;
        if (c + 1 >= w)
        begin
            col_cnt = 0;
            row_cnt = (r + 1 >= h) ? 0 : r + 1;
        end
        else
        begin
            col_cnt = c + 1;
            row_cnt = r;
        end
        if (r + 1 >= kh && c + 1 >= kw)
        begin
            acc = '0;
            for (int kr = 0; kr < kh; kr++)
                for (int kc = 0; kc < kw; kc++)
                begin
                    a = win[kr][kc];
                    b = coeffs[(kr * kw + kc) % KSLOTS];
                    acc += a * b;
                end
            res.sum  = acc[SUM_W-1:0];
            res.row  = POS_W'(r + 1 - kh);
            res.col  = POS_W'(c + 1 - kw);
            res.last = (r == h - 1) && (c == w - 1);
            expected_sums.push_back(res);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        window_sum_t exp_sum;
        if (!rst_n)
        begin
            img_w   = 11'd1024;
            img_h   = 11'd1024;
            k_h     = 3'd3;
            k_w     = 3'd3;
            row_cnt = 0;
            col_cnt = 0;
            errors  = 0;
            expected_sums.delete();
            for (int i = 0; i < KSLOTS; i++)
                coeffs[i] = '0;
            for (int i = 0; i < KMAX; i++)
                for (int j = 0; j < KMAX; j++)
                    win[i][j] = '0;
            for (int i = 0; i < NLINES; i++)
                for (int j = 0; j < WMAX; j++)
                    lines[i][j] = '0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_sums.size() == 0)
                begin
                    $error("result transaction with no expected sum waiting");
                    errors++;
                end
                else
                begin
                    exp_sum = expected_sums.pop_front();
                    if (rsp.sum !== exp_sum.sum)
                    begin
                        $error("sum: expected %0d, actual %0d", exp_sum.sum, rsp.sum);
                        errors++;
                    end
                    if (rsp.out_row !== exp_sum.row)
                    begin
                        $error("out_row: expected %0d, actual %0d", exp_sum.row,
                               rsp.out_row);
                        errors++;
                    end
                    if (rsp.out_col !== exp_sum.col)
                    begin
                        $error("out_col: expected %0d, actual %0d", exp_sum.col,
                               rsp.out_col);
                        errors++;
                    end
                    if (rsp.last_of_image !== exp_sum.last)
                    begin
                        $error("last_of_image: expected %0d, actual %0d", exp_sum.last,
                               rsp.last_of_image);
                        errors++;
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_reg_e'(cfg_index))
                    CFG_IMAGE_WIDTH:   img_w = cfg_data;
                    CFG_IMAGE_HEIGHT:  img_h = cfg_data;
                    CFG_KERNEL_HEIGHT: k_h = cfg_data[2:0];
                    CFG_KERNEL_WIDTH:  k_w = cfg_data[2:0];
                    default: ;
                endcase
                row_cnt = 0;
                col_cnt = 0;
            end
            if (req.valid && req.ready)
            begin
                if (req.req_type == REQ_LOAD)
                begin
                    if (req.coeff_index < KSLOTS)
                        coeffs[req.coeff_index] = req.value;
                end
                else
                    apply_sample(req.value);
            end
        end
        pending = expected_sums.size();
    end

endmodule

@@ tb/tb_valid_2d_convolution.sv @@
// Testbench top for valid_2d_convolution: clock, reset, stimulus and verdict.
// Depends on vc2d_pkg, both channel interfaces, the block and the sum checker.
`timescale 1ns / 1ps

module tb_valid_2d_convolution;
    import vc2d_pkg::*;

    localparam int IDLE_LIMIT  = 3000;
    localparam int HOLD_CYCLES = 200;
    localparam int ITEM_TARGET = 1500;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    errors;
    int                    pending;
    int                    idle_cycles;
    int                    burst_left;
    int                    rx_mode;
    int                    rx_tick;
    bit                    gaps_on;
    bit                    hold_req;
    int                    samples_sent;

    vc2d_req_if req_ch ();
    vc2d_rsp_if rsp_ch ();

    valid_2d_convolution dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    vc2d_window_sum_checker u_sum_chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver: stall pattern chosen per phase, plus one long hold-off on request.
    initial
    begin
        rsp_ch.ready = 1'b0;
        rx_tick = 0;
        forever
        begin
            @(negedge clk);
            rx_tick++;
            if (hold_req)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                case (rx_mode)
                    0:       rsp_ch.ready <= 1'b1;
                    1:       rsp_ch.ready <= $urandom_range(0, 1);
                    2:       rsp_ch.ready <= ($urandom_range(0, 4) == 0);
                    default: rsp_ch.ready <= (rx_tick % 5 != 0);
                endcase
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(input logic kind, input logic [COEFF_IDX_W-1:0] idx,
                             input logic [SAMPLE_W-1:0] val);
        int gap;
        if (gaps_on && burst_left <= 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= kind;
        req_ch.coeff_index <= idx;
        req_ch.value       <= val;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        @(negedge clk);
        burst_left--;
        if (kind == REQ_SAMPLE)
            samples_sent++;
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic configure(input int w, input int h, input int kh, input int kw);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IMAGE_WIDTH;
        cfg_data  <= CFG_DATA_W'(w);
        @(negedge clk);
        cfg_index <= CFG_IMAGE_HEIGHT;
        cfg_data  <= CFG_DATA_W'(h);
        @(negedge clk);
        cfg_index <= CFG_KERNEL_HEIGHT;
        cfg_data  <= CFG_DATA_W'(kh);
        @(negedge clk);
        cfg_index <= CFG_KERNEL_WIDTH;
        cfg_data  <= CFG_DATA_W'(kw);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send_samples(input int n, input int load_pct);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < load_pct)
                send_item(REQ_LOAD, COEFF_IDX_W'($urandom), pick_value());
            send_item(REQ_SAMPLE, COEFF_IDX_W'($urandom), pick_value());
        end
    endtask

    initial
    begin
        int w, h, kh, kw, n;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_IMAGE_WIDTH;
        cfg_data           = '0;
        req_ch.valid       = 1'b0;
        req_ch.req_type    = REQ_LOAD;
        req_ch.coeff_index = '0;
        req_ch.value       = '0;
        idle_cycles        = 0;
        burst_left         = 0;
        rx_mode            = 0;
        gaps_on            = 1'b0;
        hold_req           = 1'b0;
        samples_sent       = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: extreme coefficients, ignored slots, samples under reset sizes.
        send_item(REQ_LOAD, 5'd0, 16'h7FFF);
        send_item(REQ_LOAD, 5'd24, 16'h8000);
        send_item(REQ_LOAD, 5'd31, 16'h5A5A);
        send_item(REQ_LOAD, 5'd25, 16'hA5A5);
        send_item(REQ_SAMPLE, 5'd31, 16'h7FFF);
        send_item(REQ_SAMPLE, 5'd0, 16'h8000);

        // A single full 3x3 window with the largest magnitudes.
        configure(3, 3, 3, 3);
        for (int i = 0; i < 9; i++)
            send_item(REQ_LOAD, COEFF_IDX_W'(i), 16'h8000);
        for (int i = 0; i < 9; i++)
            send_item(REQ_SAMPLE, '0, 16'h8000);

        // Kernel larger than the image, sizes out of range on both sides.
        configure(2, 2, 7, 0);
        for (int i = 0; i < 4; i++)
            send_item(REQ_SAMPLE, '0, 16'h7FFF);

        // Widest image while the receiver holds off, so the input backs up.
        rx_mode = 1;
        configure(2047, 1, 0, 3);
        for (int i = 0; i < 3; i++)
            send_item(REQ_LOAD, COEFF_IDX_W'(i), pick_value());
        hold_req = 1'b1;
        send_samples(1024, 0);

        // Tallest image, single-column kernel.
        rx_mode = 3;
        configure(0, 2047, 7, 1);
        for (int i = 0; i < 5; i++)
            send_item(REQ_LOAD, COEFF_IDX_W'(i), pick_value());
        gaps_on = 1'b1;
        send_samples(1024, 0);

        // Random phases: mostly well-formed images, some noise and partial images.
        samples_sent = 0;
        while (samples_sent < ITEM_TARGET)
        begin
            w  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 16);
            h  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(1, 10);
            kh = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 5);
            kw = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 5);
            rx_mode = $urandom_range(0, 3);
            gaps_on = $urandom_range(0, 3) != 0;
            configure(w, h, kh, kw);
            for (int i = 0; i < 25; i++)
                if ($urandom_range(0, 2) != 0)
                    send_item(REQ_LOAD, COEFF_IDX_W'(i), pick_value());
            if ($urandom_range(0, 1) == 0)
                send_item(REQ_LOAD, COEFF_IDX_W'($urandom_range(25, 31)), pick_value());
            if (w < 1)
                w = 1;
            if (h < 1)
                h = 1;
            n = w * h * $urandom_range(1, 2) + $urandom_range(0, w);
            send_samples(n, 3);
        end

        wait_idle();
        repeat (20) @(negedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
